>>> rtl/core/rps_pkg.sv
// ----------------------------------------------------------------------------
// rps_pkg
// Shared widths, codes and controller/datapath interface types for the
// random permutation shuffler.
// ----------------------------------------------------------------------------
package rps_pkg;

  // Field widths of the item and result transactions.
  localparam int KIND_W   = 2;
  localparam int RANDOM_W = 31;
  localparam int INDEX_W  = 16;
  localparam int VALUE_W  = 16;
  localparam int COUNT_W  = 17;

  // Default table depth and the reset value of the entry count register.
  localparam int                 TABLE_ENTRIES_DEF = 65536;
  localparam logic [COUNT_W-1:0] ENTRY_COUNT_RST   = 17'd60000;

  // Register map: paddr bit 2 selects the register word.
  localparam int   PADDR_W          = 3;
  localparam logic REG_ENTRY_COUNT  = 1'b0;

  // Item kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_FILL = 2'd0,
    KIND_STEP = 2'd1,
    KIND_READ = 2'd2
  } kind_t;

  // Table read address source.
  typedef enum logic [1:0] {
    RD_CURSOR  = 2'd0,
    RD_PARTNER = 2'd1,
    RD_INDEX   = 2'd2
  } rd_sel_t;

  // Table write address and data source.
  typedef enum logic [1:0] {
    WR_FILL    = 2'd0,
    WR_CURSOR  = 2'd1,
    WR_PARTNER = 2'd2
  } wr_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    capture;      // latch the accepted item
    logic    fill_start;   // reset the fill counter, drop the loaded cursor
    logic    fill_write;   // write one identity entry and advance
    logic    step_single;  // pass of one entry: report done only
    logic    step_begin;   // commit cursor and start the remainder unit
    logic    hold_cursor;  // keep the entry read at the cursor
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    step_end;     // move the cursor down, flag end of pass
    logic    result_load;  // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              read_ok;
    logic              cur_zero;
    logic              mod_done;
    logic              fill_last;
    logic              slot_free;
  } status_t;

endpackage

>>> rtl/core/rps_ram.sv
// ----------------------------------------------------------------------------
// rps_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered, enabled read.
// ----------------------------------------------------------------------------
module rps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds until the next enabled read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/rps_mod.sv
// ----------------------------------------------------------------------------
// rps_mod
// Iterative remainder unit: 31-bit dividend modulo a narrow divisor,
// one dividend bit per cycle by restoring division.
// ----------------------------------------------------------------------------
module rps_mod
  import rps_pkg::*;
#(
  parameter int DW = 17
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [RANDOM_W-1:0] dividend,
  input  logic [DW-1:0]       divisor,
  output logic                done,
  output logic [DW-1:0]       rem
);

  localparam int CNT_W = $clog2(RANDOM_W + 1);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [RANDOM_W-1:0] dvd_r, dvd_nxt;
  logic [DW-1:0]       dvs_r, dvs_nxt;
  logic [DW-1:0]       rem_r, rem_nxt;
  logic [DW:0]         shifted;

  // One restoring step: bring down the next dividend bit, subtract if it fits.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    shifted  = {rem_r, dvd_r[RANDOM_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(RANDOM_W);
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[RANDOM_W-2:0], 1'b0};
      if (shifted >= {1'b0, dvs_r}) begin
        rem_nxt = DW'(shifted - {1'b0, dvs_r});
      end else begin
        rem_nxt = DW'(shifted);
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Operands and partial remainder.
  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

>>> rtl/core/rps_datapath.sv
// ----------------------------------------------------------------------------
// rps_datapath
// Permutation table, step cursor, entry count register, remainder unit and
// the output register of the shuffler.
// ----------------------------------------------------------------------------
module rps_datapath
  import rps_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  output status_t             status,
  input  logic [KIND_W-1:0]   in_kind,
  input  logic [RANDOM_W-1:0] in_random_word,
  input  logic [INDEX_W-1:0]  in_read_index,
  input  logic                cfg_we,
  input  logic [COUNT_W-1:0]  cfg_wdata,
  output logic [COUNT_W-1:0]  entry_count,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [VALUE_W-1:0]  out_entry_value,
  output logic                out_pass_done
);

  localparam int AW    = $clog2(TABLE_ENTRIES);
  localparam int DW    = AW + 1;
  localparam int CMP_W = (COUNT_W > DW) ? COUNT_W : DW;
  localparam int IDX_W = (INDEX_W + 1 > DW) ? INDEX_W + 1 : DW;

  logic [KIND_W-1:0]   kind_r;
  logic [RANDOM_W-1:0] rnd_r;
  logic [AW-1:0]       ridx_r;
  logic                read_ok_r;
  logic [COUNT_W-1:0]  entry_count_r;
  logic                loaded_r;
  logic [AW-1:0]       cursor_r;
  logic [AW-1:0]       fill_addr_r;
  logic [VALUE_W-1:0]  held_r;
  logic                done_r;
  logic                out_valid_r;
  logic [VALUE_W-1:0]  out_value_r;
  logic                out_done_r;

  logic [AW-1:0]       load_val;
  logic [AW-1:0]       cur_eff;
  logic                mod_done;
  logic [DW-1:0]       mod_rem;
  logic [AW-1:0]       partner;
  logic [AW-1:0]       raddr;
  logic [AW-1:0]       waddr;
  logic [VALUE_W-1:0]  wdata;
  logic [VALUE_W-1:0]  rdata;

  // Cursor start value: the entry count, saturated to 1..TABLE_ENTRIES, minus one.
  always_comb begin
    if (entry_count_r == '0) begin
      load_val = '0;
    end else if (CMP_W'(entry_count_r) > CMP_W'(TABLE_ENTRIES)) begin
      load_val = AW'(TABLE_ENTRIES - 1);
    end else begin
      load_val = AW'(entry_count_r - COUNT_W'(1));
    end
  end

  assign cur_eff = loaded_r ? cursor_r : load_val;
  assign partner = AW'(mod_rem);

  // Swap partner index: random word modulo (cursor + 1).
  rps_mod #(
    .DW (DW)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.step_begin),
    .dividend (rnd_r),
    .divisor  (DW'(cur_eff) + DW'(1)),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // Table address and data selection.
  always_comb begin
    case (cmd.rd_sel)
      RD_CURSOR:  raddr = cursor_r;
      RD_PARTNER: raddr = partner;
      RD_INDEX:   raddr = ridx_r;
      default:    raddr = cursor_r;
    endcase
    case (cmd.wr_sel)
      WR_FILL: begin
        waddr = fill_addr_r;
        wdata = VALUE_W'(fill_addr_r);
      end
      WR_CURSOR: begin
        waddr = cursor_r;
        wdata = rdata;
      end
      WR_PARTNER: begin
        waddr = partner;
        wdata = held_r;
      end
      default: begin
        waddr = fill_addr_r;
        wdata = VALUE_W'(fill_addr_r);
      end
    endcase
  end

  rps_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Item fields and swap scratch.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r    <= in_kind;
      rnd_r     <= in_random_word;
      ridx_r    <= AW'(in_read_index);
      read_ok_r <= IDX_W'(in_read_index) < IDX_W'(TABLE_ENTRIES);
    end
    if (cmd.hold_cursor) begin
      held_r <= rdata;
    end
  end

  // Entry count register, cursor, fill counter and pass flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= ENTRY_COUNT_RST;
      loaded_r      <= 1'b0;
      cursor_r      <= '0;
      fill_addr_r   <= '0;
      done_r        <= 1'b0;
    end else begin
      if (cfg_we) begin
        entry_count_r <= cfg_wdata;
        loaded_r      <= 1'b0;
      end
      if (cmd.capture) begin
        done_r <= 1'b0;
      end
      if (cmd.fill_start) begin
        fill_addr_r <= '0;
        loaded_r    <= 1'b0;
      end
      if (cmd.fill_write) begin
        fill_addr_r <= fill_addr_r + AW'(1);
      end
      if (cmd.step_single) begin
        done_r   <= 1'b1;
        loaded_r <= 1'b0;
      end
      if (cmd.step_begin) begin
        cursor_r <= cur_eff;
        loaded_r <= 1'b1;
      end
      if (cmd.step_end) begin
        cursor_r <= cursor_r - AW'(1);
        if (cursor_r == AW'(1)) begin
          done_r   <= 1'b1;
          loaded_r <= 1'b0;
        end
      end
    end
  end

  // Output register: holds one result until the consumer takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.result_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      out_value_r <= (kind_r == KIND_READ && read_ok_r) ? rdata : '0;
      out_done_r  <= done_r;
    end
  end

  always_comb begin
    status.kind      = kind_r;
    status.read_ok   = read_ok_r;
    status.cur_zero  = (cur_eff == '0);
    status.mod_done  = mod_done;
    status.fill_last = (fill_addr_r == AW'(TABLE_ENTRIES - 1));
    status.slot_free = !out_valid_r || out_ready;
  end

  assign entry_count     = entry_count_r;
  assign out_valid       = out_valid_r;
  assign out_entry_value = out_value_r;
  assign out_pass_done   = out_done_r;

endmodule

>>> rtl/core/rps_ctrl.sv
// ----------------------------------------------------------------------------
// rps_ctrl
// Sequencer of the shuffler: accepts one transaction at a time and steps the
// datapath through fill, shuffle step or read.
// ----------------------------------------------------------------------------
module rps_ctrl
  import rps_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_DISPATCH = 11'b000_0000_0010,
    S_FILL     = 11'b000_0000_0100,
    S_LOAD     = 11'b000_0000_1000,
    S_DIV      = 11'b000_0001_0000,
    S_RD_CUR   = 11'b000_0010_0000,
    S_RD_PART  = 11'b000_0100_0000,
    S_WR_CUR   = 11'b000_1000_0000,
    S_WR_PART  = 11'b001_0000_0000,
    S_RD_ENTRY = 11'b010_0000_0000,
    S_DONE     = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rd_sel = RD_CURSOR;
    cmd.wr_sel = WR_FILL;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (status.kind)
          KIND_FILL: begin
            cmd.fill_start = 1'b1;
            state_nxt      = S_FILL;
          end
          KIND_STEP: state_nxt = S_LOAD;
          KIND_READ: state_nxt = status.read_ok ? S_RD_ENTRY : S_DONE;
          default:   state_nxt = S_DONE;
        endcase
      end
      S_FILL: begin
        cmd.fill_write = 1'b1;
        cmd.wr_en      = 1'b1;
        cmd.wr_sel     = WR_FILL;
        if (status.fill_last) begin
          state_nxt = S_DONE;
        end
      end
      S_LOAD: begin
        if (status.cur_zero) begin
          cmd.step_single = 1'b1;
          state_nxt       = S_DONE;
        end else begin
          cmd.step_begin = 1'b1;
          state_nxt      = S_DIV;
        end
      end
      S_DIV: begin
        if (status.mod_done) begin
          state_nxt = S_RD_CUR;
        end
      end
      S_RD_CUR: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_CURSOR;
        state_nxt  = S_RD_PART;
      end
      S_RD_PART: begin
        cmd.hold_cursor = 1'b1;
        cmd.rd_en       = 1'b1;
        cmd.rd_sel      = RD_PARTNER;
        state_nxt       = S_WR_CUR;
      end
      S_WR_CUR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_CURSOR;
        state_nxt  = S_WR_PART;
      end
      S_WR_PART: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_sel   = WR_PARTNER;
        cmd.step_end = 1'b1;
        state_nxt    = S_DONE;
      end
      S_RD_ENTRY: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_INDEX;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (status.slot_free) begin
          cmd.result_load = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/core/random_permutation_shuffler.sv
// ----------------------------------------------------------------------------
// random_permutation_shuffler
// Fisher-Yates permutation table with fill, shuffle-step and read items.
// ----------------------------------------------------------------------------
// The block takes one transaction at a time; a finished result waits in an
// output register so the next transaction can be accepted meanwhile. A
// shuffle step is paced by the remainder unit that retires one bit of the
// 31-bit random word per cycle, plus two table reads and two table writes on
// the single-write-port table RAM. A step that only ends a pass of one entry
// skips the remainder unit and the table, a read makes one table read, and a
// fill writes one entry per cycle. The table holds no defined value until
// a fill. The entry count register sits at byte address 0 of the APB port.
// ----------------------------------------------------------------------------
module random_permutation_shuffler
  import rps_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // Item channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [KIND_W-1:0]   in_kind,
  input  logic [RANDOM_W-1:0] in_random_word,
  input  logic [INDEX_W-1:0]  in_read_index,
  // Result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic [VALUE_W-1:0]  out_entry_value,
  output logic                out_pass_done,
  // Configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  cmd_t               cmd;
  status_t            status;
  logic               cfg_we;
  logic [COUNT_W-1:0] entry_count;

  // Register access decode.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_ENTRY_COUNT);
  assign prdata = (paddr[2] == REG_ENTRY_COUNT) ? 32'(entry_count) : '0;

  rps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  rps_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_kind         (in_kind),
    .in_random_word  (in_random_word),
    .in_read_index   (in_read_index),
    .cfg_we          (cfg_we),
    .cfg_wdata       (pwdata[COUNT_W-1:0]),
    .entry_count     (entry_count),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_entry_value (out_entry_value),
    .out_pass_done   (out_pass_done)
  );

endmodule

>>> dv/rps_table_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rps_table_checker
// Watches the item, result and APB channels of the permutation shuffler. It
// keeps its own copy of the table, the cursor and the entry count, predicts
// one result per accepted transaction and compares every returned result with
// the oldest prediction.
// ----------------------------------------------------------------------------
module rps_table_checker
  import rps_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [KIND_W-1:0]   in_kind,
  input  logic [RANDOM_W-1:0] in_random_word,
  input  logic [INDEX_W-1:0]  in_read_index,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [VALUE_W-1:0]  out_entry_value,
  input  logic                out_pass_done,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [31:0]         pwdata,
  input  logic                pready,
  output int                  mismatches,
  output int                  outstanding,
  output int                  results_checked,
  output int                  passes_seen
);

  localparam logic [PADDR_W-1:0] ENTRY_COUNT_ADDR = {REG_ENTRY_COUNT, 2'b00};
  localparam int                 MAX_REPORTS      = 10;

  typedef struct packed {
    logic [VALUE_W-1:0] entry_value;
    logic               pass_done;
  } table_result_t;

  // Shadow copy of the block's state.
  logic [VALUE_W-1:0] perm_table [TABLE_DEPTH];
  logic [COUNT_W-1:0] entry_count;
  logic [COUNT_W-1:0] step_cursor;
  logic               cursor_loaded;

  table_result_t      predicted_results [$];
  int                 mismatch_total;
  int                 checked_total;
  int                 pass_total;

  // The count register saturates to 1..TABLE_DEPTH when a pass starts.
  function automatic logic [COUNT_W-1:0] active_count();
    if (entry_count == '0) begin
      return COUNT_W'(1);
    end
    if (entry_count > TABLE_DEPTH) begin
      return COUNT_W'(TABLE_DEPTH);
    end
    return entry_count;
  endfunction

  // Applies one transaction to the shadow table and returns its result.
  function automatic table_result_t apply_table_item(
    input logic [KIND_W-1:0]   kind,
    input logic [RANDOM_W-1:0] rnd,
    input logic [INDEX_W-1:0]  idx
  );
    table_result_t      res;
    logic [31:0]        span;
    logic [31:0]        partner;
    logic [VALUE_W-1:0] held;
    int                 k;
    res = '0;
    case (kind)
      KIND_FILL: begin
        for (k = 0; k < TABLE_DEPTH; k++) begin
          perm_table[k] = k[VALUE_W-1:0];
        end
        cursor_loaded = 1'b0;
      end
      KIND_STEP: begin
        if (!cursor_loaded) begin
          step_cursor   = active_count() - COUNT_W'(1);
          cursor_loaded = 1'b1;
        end
        // A pass of a single entry only reports its end.
        if (step_cursor < 1 || step_cursor >= TABLE_DEPTH) begin
          res.pass_done = 1'b1;
          cursor_loaded = 1'b0;
        end else begin
          span                     = 32'(step_cursor) + 32'd1;
          partner                  = 32'(rnd) % span;
          held                     = perm_table[step_cursor];
          perm_table[step_cursor]  = perm_table[partner];
          perm_table[partner]      = held;
          step_cursor              = step_cursor - COUNT_W'(1);
          if (step_cursor < 1) begin
            res.pass_done = 1'b1;
            cursor_loaded = 1'b0;
          end
        end
      end
      KIND_READ: begin
        if (idx < TABLE_DEPTH) begin
          res.entry_value = perm_table[idx];
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : watch
    table_result_t want;
    if (!rst_n) begin
      entry_count    = ENTRY_COUNT_RST;
      step_cursor    = ENTRY_COUNT_RST - COUNT_W'(1);
      cursor_loaded  = 1'b0;
      mismatch_total = 0;
      checked_total  = 0;
      pass_total     = 0;
      predicted_results.delete();
    end else begin
      // A count write also drops any pass in progress.
      if (psel && penable && pwrite && pready && paddr == ENTRY_COUNT_ADDR) begin
        entry_count   = pwdata[COUNT_W-1:0];
        cursor_loaded = 1'b0;
      end

      // Compare a returned result with the oldest prediction.
      if (out_valid && out_ready) begin
        checked_total++;
        if (out_pass_done === 1'b1) begin
          pass_total++;
        end
        if (predicted_results.size() == 0) begin
          mismatch_total++;
          if (mismatch_total <= MAX_REPORTS) begin
            $display("ERROR %0t: result with no transaction pending: value %h done %b",
                     $realtime, out_entry_value, out_pass_done);
          end
        end else begin
          want = predicted_results.pop_front();
          if (out_entry_value !== want.entry_value || out_pass_done !== want.pass_done)
          begin
            mismatch_total++;
            if (mismatch_total <= MAX_REPORTS) begin
              $display("ERROR %0t: result %0d: value exp %h got %h, done exp %b got %b",
                       $realtime, checked_total, want.entry_value, out_entry_value,
                       want.pass_done, out_pass_done);
            end
          end
        end
      end

      // Predict the result of a newly accepted transaction.
      if (in_valid && in_ready) begin
        predicted_results.push_back(
          apply_table_item(in_kind, in_random_word, in_read_index));
      end
    end
    mismatches      <= mismatch_total;
    outstanding     <= predicted_results.size();
    results_checked <= checked_total;
    passes_seen     <= pass_total;
  end

endmodule

>>> dv/random_permutation_shuffler_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// random_permutation_shuffler_tb
// Drives fill, shuffle-step, read and unknown transactions into the shuffler
// under random sender gaps and receiver stalls, rewrites the entry count
// between phases, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module random_permutation_shuffler_tb;
  import rps_pkg::*;

  localparam logic [KIND_W-1:0]  KIND_NONE        = 2'd3;
  localparam logic [PADDR_W-1:0] ENTRY_COUNT_ADDR = {REG_ENTRY_COUNT, 2'b00};
  localparam int                 ITEM_TARGET      = 1850;
  localparam int                 CYCLE_LIMIT      = 4_000_000;
  localparam int                 MAX_GAP          = 19;
  localparam int                 RANDOM_FILLS     = 4;
  localparam int                 SETTLE_CYCLES    = 60;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [KIND_W-1:0]   in_kind;
  logic [RANDOM_W-1:0] in_random_word;
  logic [INDEX_W-1:0]  in_read_index;
  logic                out_valid;
  logic                out_ready;
  logic [VALUE_W-1:0]  out_entry_value;
  logic                out_pass_done;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  int                  mismatches;
  int                  outstanding;
  int                  results_checked;
  int                  passes_seen;

  logic                idling = 1'b1;
  logic [COUNT_W-1:0]  current_count = ENTRY_COUNT_RST;
  int                  cycle_count;
  int                  items_sent;
  int                  fills_sent;
  int                  steps_sent;
  int                  reads_sent;
  int                  unknown_sent;
  int                  config_writes;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  random_permutation_shuffler u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_random_word  (in_random_word),
    .in_read_index   (in_read_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_entry_value (out_entry_value),
    .out_pass_done   (out_pass_done),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  rps_table_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_random_word  (in_random_word),
    .in_read_index   (in_read_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_entry_value (out_entry_value),
    .out_pass_done   (out_pass_done),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .passes_seen     (passes_seen)
  );

  // Offers one transaction, after a random gap while idling is on, and waits until it is taken.
  task automatic send_item(
    input logic [KIND_W-1:0]   kind,
    input logic [RANDOM_W-1:0] rnd,
    input logic [INDEX_W-1:0]  idx
  );
    int gap;
    gap = idling ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_random_word <= rnd;
    in_read_index  <= idx;
    do @(posedge clk); while (!in_ready);
    case (kind)
      KIND_FILL: fills_sent++;
      KIND_STEP: steps_sent++;
      KIND_READ: reads_sent++;
      default:   unknown_sent++;
    endcase
    if (kind != KIND_NONE) begin
      items_sent++;
    end
  endtask

  // Holds off the sender until every predicted result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // APB write of the entry count: setup phase, then access phase.
  task automatic write_entry_count(input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ENTRY_COUNT_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    current_count = value[COUNT_W-1:0];
    config_writes++;
  endtask

  // Result side: a random stall before each result, none while idling is off.
  initial begin : result_sink
    int stall;
    out_ready <= 1'b0;
    forever begin
      stall = idling ? $urandom_range(0, MAX_GAP) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Watchdog on the total run length.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d results still due", cycle_count, outstanding);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    int                  phase_len;
    int                  pick;
    int                  fills_left;
    int                  active;
    logic [RANDOM_W-1:0] rnd;
    logic [INDEX_W-1:0]  idx;

    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_kind        <= KIND_NONE;
    in_random_word <= '0;
    in_read_index  <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: an unknown kind is harmless before the table is filled.
    send_item(KIND_NONE, '0, '0);
    send_item(KIND_FILL, '1, '1);
    send_item(KIND_READ, '0, 16'd0);
    send_item(KIND_READ, '0, 16'hFFFF);
    // Steps at the reset count with the extreme random words.
    send_item(KIND_STEP, 31'd0, '0);
    send_item(KIND_STEP, 31'h7FFF_FFFF, '1);
    send_item(KIND_READ, '1, 16'd59999);
    send_item(KIND_READ, '1, 16'd59998);
    send_item(KIND_READ, '1, 16'd0);
    // A fill in the middle of a pass restarts the cursor.
    send_item(KIND_FILL, '0, '0);
    send_item(KIND_STEP, 31'h2AAA_AAAA, 16'h5555);
    send_item(KIND_READ, '0, 16'd59999);
    send_item(KIND_NONE, '1, '1);
    drain_results();

    // Single entry: every step just ends a pass.
    write_entry_count(32'd1);
    send_item(KIND_STEP, 31'h7FFF_FFFF, '0);
    send_item(KIND_STEP, 31'd5, '0);
    send_item(KIND_READ, '0, 16'd0);
    drain_results();

    // Two entries: each step is a full pass.
    write_entry_count(32'd2);
    send_item(KIND_STEP, 31'd1, '0);
    send_item(KIND_STEP, 31'd3, '0);
    send_item(KIND_READ, '0, 16'd0);
    send_item(KIND_READ, '0, 16'd1);
    drain_results();

    // Counts outside 1..TABLE_ENTRIES saturate.
    write_entry_count(32'd0);
    send_item(KIND_STEP, 31'h1234_5678, '0);
    drain_results();
    write_entry_count(32'h0001_FFFF);
    send_item(KIND_STEP, 31'h7FFF_FFFF, '0);
    send_item(KIND_READ, '0, 16'hFFFF);

    // Random phases, each with a fresh count and its own idling mode.
    fills_left = RANDOM_FILLS;
    while (items_sent < ITEM_TARGET) begin
      drain_results();
      case ($urandom_range(0, 9))
        0: write_entry_count(32'd1);
        1: write_entry_count(32'd2);
        2: write_entry_count(32'd3);
        3, 4, 5: write_entry_count($urandom_range(4, 16));
        6: write_entry_count($urandom_range(17, 400));
        7: begin
          case ($urandom_range(0, 3))
            0: write_entry_count(32'd0);
            1: write_entry_count(32'd65536);
            2: write_entry_count(32'h0001_FFFF);
            default: write_entry_count(32'd60000);
          endcase
        end
        8: write_entry_count($urandom);
        default: write_entry_count($urandom_range(4, 40));
      endcase
      idling <= ($urandom_range(0, 4) != 0);
      if (current_count == '0) begin
        active = 1;
      end else if (current_count > TABLE_ENTRIES_DEF) begin
        active = TABLE_ENTRIES_DEF;
      end else begin
        active = int'(current_count);
      end
      phase_len = $urandom_range(30, 120);

      // Mostly shuffle steps, with reads biased into the shuffled range.
      repeat (phase_len) begin
        pick = $urandom_range(0, 99);
        rnd  = RANDOM_W'($urandom);
        if ($urandom_range(0, 15) == 0) begin
          rnd = ($urandom_range(0, 1) == 1) ? '1 : '0;
        end
        idx = INDEX_W'($urandom);
        if (fills_left > 0 && $urandom_range(0, 299) == 0) begin
          fills_left--;
          send_item(KIND_FILL, rnd, idx);
        end else if (pick < 66) begin
          send_item(KIND_STEP, rnd, idx);
        end else if (pick < 97) begin
          if ($urandom_range(0, 3) != 0) begin
            idx = INDEX_W'($urandom_range(0, active - 1));
          end
          send_item(KIND_READ, rnd, idx);
        end else begin
          send_item(KIND_NONE, rnd, idx);
        end
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d transactions (%0d fills, %0d steps, %0d reads, %0d unknown)",
             items_sent + unknown_sent, fills_sent, steps_sent, reads_sent, unknown_sent);
    $display("over %0d count writes; checked %0d results with %0d shuffle passes in %0d cycles",
             config_writes, results_checked, passes_seen, cycle_count);
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results never returned", mismatches, outstanding);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/rps_pkg.sv
rtl/core/rps_ram.sv
rtl/core/rps_mod.sv
rtl/core/rps_datapath.sv
rtl/core/rps_ctrl.sv
rtl/core/random_permutation_shuffler.sv
dv/rps_table_checker.sv
dv/random_permutation_shuffler_tb.sv
